>>> rtl/core/efdhr_pkg.sv
package efdhr_pkg;

    // filter sample limits, counts in Q.8
    localparam logic signed [23:0] Y_MAX = 24'sh7FFFFF;
    localparam logic signed [23:0] Y_MIN = -24'sh800000;

    // accumulator width of the shared multiplier
    localparam int ACC_W = 42;
    // dividend width of the shared divider
    localparam int DVD_W = 22;

    // beats per minute x16 times one thousand
    localparam logic [DVD_W-1:0] RATE_NUM = 22'd960000;
    localparam logic [13:0] RATE_MAX = 14'd16383;
    localparam logic [15:0] DIV_TEN = 16'd10;

    // register indexes
    localparam logic [2:0] REG_B0      = 3'd0;
    localparam logic [2:0] REG_B2      = 3'd1;
    localparam logic [2:0] REG_A1      = 3'd2;
    localparam logic [2:0] REG_A2      = 3'd3;
    localparam logic [2:0] REG_THRESH  = 3'd4;
    localparam logic [2:0] REG_MIN_RR  = 3'd5;
    localparam logic [2:0] REG_ROW_OFS = 3'd6;
    localparam logic [2:0] REG_ROW_GN  = 3'd7;

    // register reset values
    localparam logic [15:0] B0_RST      = 16'd1106;
    localparam logic [15:0] B2_RST      = 16'hFBAE;
    localparam logic [15:0] A1_RST      = 16'h8864;
    localparam logic [15:0] A2_RST      = 16'd14174;
    localparam logic [15:0] THRESH_RST  = 16'd2855;
    localparam logic [15:0] MIN_RR_RST  = 16'd200;
    localparam logic [7:0]  ROW_OFS_RST = 8'd90;
    localparam logic [15:0] ROW_GN_RST  = 16'd2640;

    typedef enum logic [9:0] {
        ST_IDLE      = 10'b0000000001,
        ST_MUL_ISSUE = 10'b0000000010,
        ST_MUL_WAIT  = 10'b0000000100,
        ST_FILT      = 10'b0000001000,
        ST_CHOOSE    = 10'b0000010000,
        ST_ROW_WAIT  = 10'b0000100000,
        ST_ROW_FIN   = 10'b0001000000,
        ST_DIV1_WAIT = 10'b0010000000,
        ST_DIV2_WAIT = 10'b0100000000,
        ST_DONE      = 10'b1000000000
    } state_t;

    // command to the serial multiplier
    typedef struct packed {
        logic start;
        logic clear;
        logic neg;
        logic signed_mplier;
    } mac_cmd_t;

endpackage

>>> rtl/core/efdhr_mac.sv
module efdhr_mac (
    input  logic                         clk,
    input  logic                         rst_n,
    input  efdhr_pkg::mac_cmd_t          cmd,
    input  logic [efdhr_pkg::ACC_W-1:0]  mcand,
    input  logic [15:0]                  mplier,
    output logic [efdhr_pkg::ACC_W-1:0]  acc,
    output logic                         done
);

    logic                        busy_reg;
    logic                        done_reg;
    logic [3:0]                  cnt_reg;
    logic [efdhr_pkg::ACC_W-1:0] mcand_reg;
    logic [15:0]                 mplier_reg;
    logic                        neg_reg;
    logic                        sgn_reg;
    logic [efdhr_pkg::ACC_W-1:0] acc_reg;
    logic [efdhr_pkg::ACC_W-1:0] addend;
    logic                        sub;

    // one multiplier bit per cycle, top bit weighs negative when signed
    always_comb
    begin
        addend = mplier_reg[0] ? mcand_reg : '0;
        sub = neg_reg ^ (sgn_reg && (cnt_reg == 4'd15));
    end

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (cmd.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 4'd1;
                if (cnt_reg == 4'd15)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            mcand_reg  <= mcand;
            mplier_reg <= mplier;
            neg_reg    <= cmd.neg;
            sgn_reg    <= cmd.signed_mplier;
            if (cmd.clear)
            begin
                acc_reg <= '0;
            end
        end
        else if (busy_reg)
        begin
            acc_reg    <= sub ? acc_reg - addend : acc_reg + addend;
            mcand_reg  <= {mcand_reg[efdhr_pkg::ACC_W-2:0], 1'b0};
            mplier_reg <= {1'b0, mplier_reg[15:1]};
        end
    end

    assign acc  = acc_reg;
    assign done = done_reg;

endmodule

>>> rtl/core/efdhr_div.sv
module efdhr_div (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [efdhr_pkg::DVD_W-1:0]  dividend,
    input  logic [15:0]                  divisor,
    output logic [efdhr_pkg::DVD_W-1:0]  quotient,
    output logic                         done
);

    logic                        busy_reg;
    logic                        done_reg;
    logic [4:0]                  cnt_reg;
    logic [efdhr_pkg::DVD_W-1:0] dq_reg;
    logic [15:0]                 rem_reg;
    logic [15:0]                 dvs_reg;
    logic [16:0]                 sh;
    logic [16:0]                 diff;
    logic                        ge;

    // restoring step, one quotient bit per cycle
    always_comb
    begin
        sh   = {rem_reg, dq_reg[efdhr_pkg::DVD_W-1]};
        diff = sh - {1'b0, dvs_reg};
        ge   = (sh >= {1'b0, dvs_reg});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 5'd1;
                if (cnt_reg == 5'(efdhr_pkg::DVD_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dq_reg  <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= ge ? diff[15:0] : sh[15:0];
            dq_reg  <= {dq_reg[efdhr_pkg::DVD_W-2:0], ge};
        end
    end

    assign quotient = dq_reg;
    assign done     = done_reg;

endmodule

>>> rtl/core/ecg_filter_decimate_heart_rate_unit.sv
// ECG band-pass filter, window decimator and heart-rate tracker.
// Input channel: in_valid / in_stall with adc_sample, one 12-bit sample per item.
// Output channel: out_valid / out_stall with trace_value, screen_row, peak_found
// and heart_rate_x16; one item leaves for every DECIMATION samples taken in.
// Config channel: cfg_valid / cfg_ready with cfg_index and cfg_data; cfg_ready
// is always high, write only while the block is idle.
// Each sample runs four bit-serial products on one shared multiplier, each with
// its issue and wait states; in_stall stays high until the sequencer returns
// to idle, so no new sample is taken while one is being worked on.
// A sample that closes a window adds one more product for the screen row and,
// on an R peak after the first, two serial divisions (rate and divide
// by ten) before the output item is offered.
// The output register frees the output side: a new sample is accepted while a
// result waits; a second finished result waits in the block until the first
// is taken, holding in_stall high meanwhile.
// Reset clears filter history, window, peak state and the rate, and loads the
// register defaults; there is no clearing pass.
module ecg_filter_decimate_heart_rate_unit #(
    parameter int DECIMATION  = 10,
    parameter int SCREEN_ROWS = 135
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [11:0]        adc_sample,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [23:0] trace_value,
    output logic [7:0]         screen_row,
    output logic               peak_found,
    output logic [13:0]        heart_rate_x16,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [2:0]         cfg_index,
    input  logic [15:0]        cfg_data
);

    localparam int POS_W = (DECIMATION > 1) ? $clog2(DECIMATION) : 1;
    localparam logic [POS_W-1:0] POS_LAST = POS_W'(DECIMATION - 1);
    localparam logic signed [31:0] DEC_S = 32'(DECIMATION);
    localparam logic signed [18:0] ROW_TOP = 19'(SCREEN_ROWS - 1);

    efdhr_pkg::state_t state_reg;

    // registers
    logic [15:0] b0_reg, b2_reg, a1_reg, a2_reg, thresh_reg, min_rr_reg, gain_reg;
    logic [7:0]  ofs_reg;

    // filter and window state
    logic [11:0]        x_reg, x1_reg, x2_reg;
    logic signed [23:0] y1_reg, y2_reg;
    logic [POS_W-1:0]   pos_reg;
    logic signed [23:0] low_reg, high_reg;
    logic signed [29:0] total_reg;
    logic [1:0]         term_reg;
    logic signed [23:0] chosen_reg;
    logic [15:0]        ms_reg;
    logic               seen_reg;
    logic [13:0]        rate_reg;
    logic [7:0]         row_reg;
    logic               peak_reg;

    // output register
    logic               out_valid_reg;
    logic signed [23:0] trace_value_reg;
    logic [7:0]         screen_row_reg;
    logic               peak_found_reg;
    logic [13:0]        rate_out_reg;

    // shared units
    efdhr_pkg::mac_cmd_t            mac_cmd;
    logic [efdhr_pkg::ACC_W-1:0]    mac_mcand;
    logic [15:0]                    mac_mplier;
    logic [efdhr_pkg::ACC_W-1:0]    mac_acc;
    logic                           mac_done;
    logic                           div_start;
    logic [efdhr_pkg::DVD_W-1:0]    div_dividend;
    logic [15:0]                    div_divisor;
    logic [efdhr_pkg::DVD_W-1:0]    div_q;
    logic                           div_done;

    logic signed [efdhr_pkg::ACC_W-1:0] acc_rnd;
    logic signed [27:0]                 y_wide;
    logic signed [23:0]                 y_c;
    logic signed [24:0]                 hl_sum;
    logic signed [31:0]                 cmp_lhs;
    logic signed [31:0]                 cmp_rhs;
    logic signed [23:0]                 chosen_c;
    logic signed [efdhr_pkg::ACC_W-1:0] prod_adj;
    logic signed [17:0]                 t_c;
    logic signed [18:0]                 row_wide;
    logic [7:0]                         row_c;
    logic                               peak_c;
    logic [efdhr_pkg::DVD_W-1:0]        rate_sum;
    logic                               out_free;

    efdhr_mac u_mac (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (mac_cmd),
        .mcand  (mac_mcand),
        .mplier (mac_mplier),
        .acc    (mac_acc),
        .done   (mac_done)
    );

    efdhr_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .quotient (div_q),
        .done     (div_done)
    );

    // filter output: round half up, shift, saturate
    always_comb
    begin
        acc_rnd = $signed(mac_acc) + 42'sd8192;
        y_wide  = 28'(acc_rnd >>> 14);
        if (y_wide > 28'(efdhr_pkg::Y_MAX))
        begin
            y_c = efdhr_pkg::Y_MAX;
        end
        else if (y_wide < 28'(efdhr_pkg::Y_MIN))
        begin
            y_c = efdhr_pkg::Y_MIN;
        end
        else
        begin
            y_c = y_wide[23:0];
        end
    end

    // extreme farther from the average, tie picks the minimum
    always_comb
    begin
        hl_sum   = 25'(low_reg) + 25'(high_reg);
        cmp_lhs  = 32'(32'(hl_sum) * DEC_S);
        cmp_rhs  = 32'(total_reg) <<< 1;
        chosen_c = (cmp_lhs > cmp_rhs) ? high_reg : low_reg;
    end

    // screen row, product truncated toward zero
    always_comb
    begin
        prod_adj = $signed(mac_acc);
        if (mac_acc[efdhr_pkg::ACC_W-1])
        begin
            prod_adj = $signed(mac_acc) + 42'sd16777215;
        end
        t_c      = 18'(prod_adj >>> 24);
        row_wide = $signed({11'b0, ofs_reg}) - 19'(t_c);
        if (row_wide < 19'sd0)
        begin
            row_c = 8'd0;
        end
        else if (row_wide > ROW_TOP)
        begin
            row_c = 8'(ROW_TOP);
        end
        else
        begin
            row_c = row_wide[7:0];
        end
    end

    // peak test
    always_comb
    begin
        peak_c = (chosen_reg > $signed({thresh_reg, 8'b0}))
                 && (!seen_reg || (ms_reg > min_rr_reg));
    end

    // rate blend
    always_comb
    begin
        rate_sum = 22'(rate_reg) * 22'd7 + div_q * 22'd3 + 22'd5;
    end

    // multiplier operand select
    always_comb
    begin
        mac_cmd    = '0;
        mac_mcand  = '0;
        mac_mplier = '0;
        if (state_reg == efdhr_pkg::ST_MUL_ISSUE)
        begin
            mac_cmd.start         = 1'b1;
            mac_cmd.signed_mplier = 1'b1;
            mac_cmd.clear         = (term_reg == 2'd0);
            case (term_reg)
                2'd0:
                begin
                    mac_mcand  = {30'b0, x_reg} << 8;
                    mac_mplier = b0_reg;
                end
                2'd1:
                begin
                    mac_mcand  = {30'b0, x2_reg} << 8;
                    mac_mplier = b2_reg;
                end
                2'd2:
                begin
                    mac_mcand   = 42'(y1_reg);
                    mac_mplier  = a1_reg;
                    mac_cmd.neg = 1'b1;
                end
                default:
                begin
                    mac_mcand   = 42'(y2_reg);
                    mac_mplier  = a2_reg;
                    mac_cmd.neg = 1'b1;
                end
            endcase
        end
        else if (state_reg == efdhr_pkg::ST_CHOOSE)
        begin
            mac_cmd.start = 1'b1;
            mac_cmd.clear = 1'b1;
            mac_mcand     = 42'(chosen_c);
            mac_mplier    = gain_reg;
        end
    end

    // divider operand select
    always_comb
    begin
        div_start    = 1'b0;
        div_dividend = efdhr_pkg::RATE_NUM;
        div_divisor  = (ms_reg == 16'd0) ? 16'd1 : ms_reg;
        if (state_reg == efdhr_pkg::ST_ROW_FIN)
        begin
            div_start = peak_c && seen_reg;
        end
        else if (state_reg == efdhr_pkg::ST_DIV1_WAIT)
        begin
            div_start    = div_done;
            div_dividend = rate_sum;
            div_divisor  = efdhr_pkg::DIV_TEN;
        end
    end

    assign out_free = !out_valid_reg || !out_stall;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b0_reg     <= efdhr_pkg::B0_RST;
            b2_reg     <= efdhr_pkg::B2_RST;
            a1_reg     <= efdhr_pkg::A1_RST;
            a2_reg     <= efdhr_pkg::A2_RST;
            thresh_reg <= efdhr_pkg::THRESH_RST;
            min_rr_reg <= efdhr_pkg::MIN_RR_RST;
            ofs_reg    <= efdhr_pkg::ROW_OFS_RST;
            gain_reg   <= efdhr_pkg::ROW_GN_RST;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                efdhr_pkg::REG_B0:      b0_reg     <= cfg_data;
                efdhr_pkg::REG_B2:      b2_reg     <= cfg_data;
                efdhr_pkg::REG_A1:      a1_reg     <= cfg_data;
                efdhr_pkg::REG_A2:      a2_reg     <= cfg_data;
                efdhr_pkg::REG_THRESH:  thresh_reg <= cfg_data;
                efdhr_pkg::REG_MIN_RR:  min_rr_reg <= cfg_data;
                efdhr_pkg::REG_ROW_OFS: ofs_reg    <= cfg_data[7:0];
                default:                gain_reg   <= cfg_data;
            endcase
        end
    end

    // sequencer and state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= efdhr_pkg::ST_IDLE;
            x1_reg        <= '0;
            x2_reg        <= '0;
            y1_reg        <= '0;
            y2_reg        <= '0;
            pos_reg       <= '0;
            low_reg       <= efdhr_pkg::Y_MAX;
            high_reg      <= efdhr_pkg::Y_MIN;
            total_reg     <= '0;
            term_reg      <= '0;
            ms_reg        <= '0;
            seen_reg      <= 1'b0;
            rate_reg      <= '0;
            peak_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            // output valid: load a finished item or retire a taken one
            if ((state_reg == efdhr_pkg::ST_DONE) && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                efdhr_pkg::ST_IDLE:
                begin
                    if (in_valid)
                    begin
                        if (ms_reg != 16'hFFFF)
                        begin
                            ms_reg <= ms_reg + 16'd1;
                        end
                        term_reg  <= '0;
                        state_reg <= efdhr_pkg::ST_MUL_ISSUE;
                    end
                end
                efdhr_pkg::ST_MUL_ISSUE:
                begin
                    state_reg <= efdhr_pkg::ST_MUL_WAIT;
                end
                efdhr_pkg::ST_MUL_WAIT:
                begin
                    if (mac_done)
                    begin
                        term_reg <= term_reg + 2'd1;
                        if (term_reg == 2'd3)
                        begin
                            state_reg <= efdhr_pkg::ST_FILT;
                        end
                        else
                        begin
                            state_reg <= efdhr_pkg::ST_MUL_ISSUE;
                        end
                    end
                end
                efdhr_pkg::ST_FILT:
                begin
                    x2_reg    <= x1_reg;
                    x1_reg    <= x_reg;
                    y2_reg    <= y1_reg;
                    y1_reg    <= y_c;
                    if (y_c < low_reg)
                    begin
                        low_reg <= y_c;
                    end
                    if (y_c > high_reg)
                    begin
                        high_reg <= y_c;
                    end
                    total_reg <= total_reg + 30'(y_c);
                    if (pos_reg == POS_LAST)
                    begin
                        pos_reg   <= '0;
                        state_reg <= efdhr_pkg::ST_CHOOSE;
                    end
                    else
                    begin
                        pos_reg   <= pos_reg + POS_W'(1);
                        state_reg <= efdhr_pkg::ST_IDLE;
                    end
                end
                efdhr_pkg::ST_CHOOSE:
                begin
                    low_reg   <= efdhr_pkg::Y_MAX;
                    high_reg  <= efdhr_pkg::Y_MIN;
                    total_reg <= '0;
                    state_reg <= efdhr_pkg::ST_ROW_WAIT;
                end
                efdhr_pkg::ST_ROW_WAIT:
                begin
                    if (mac_done)
                    begin
                        state_reg <= efdhr_pkg::ST_ROW_FIN;
                    end
                end
                efdhr_pkg::ST_ROW_FIN:
                begin
                    peak_reg <= peak_c;
                    if (peak_c)
                    begin
                        seen_reg <= 1'b1;
                        ms_reg   <= '0;
                    end
                    if (peak_c && seen_reg)
                    begin
                        state_reg <= efdhr_pkg::ST_DIV1_WAIT;
                    end
                    else
                    begin
                        state_reg <= efdhr_pkg::ST_DONE;
                    end
                end
                efdhr_pkg::ST_DIV1_WAIT:
                begin
                    if (div_done)
                    begin
                        state_reg <= efdhr_pkg::ST_DIV2_WAIT;
                    end
                end
                efdhr_pkg::ST_DIV2_WAIT:
                begin
                    if (div_done)
                    begin
                        if (div_q > 22'(efdhr_pkg::RATE_MAX))
                        begin
                            rate_reg <= efdhr_pkg::RATE_MAX;
                        end
                        else
                        begin
                            rate_reg <= div_q[13:0];
                        end
                        state_reg <= efdhr_pkg::ST_DONE;
                    end
                end
                efdhr_pkg::ST_DONE:
                begin
                    if (out_free)
                    begin
                        state_reg <= efdhr_pkg::ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= efdhr_pkg::ST_IDLE;
                end
            endcase
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if ((state_reg == efdhr_pkg::ST_IDLE) && in_valid)
        begin
            x_reg <= adc_sample;
        end
        if (state_reg == efdhr_pkg::ST_CHOOSE)
        begin
            chosen_reg <= chosen_c;
        end
        if (state_reg == efdhr_pkg::ST_ROW_FIN)
        begin
            row_reg <= row_c;
        end
        if ((state_reg == efdhr_pkg::ST_DONE) && out_free)
        begin
            trace_value_reg <= chosen_reg;
            screen_row_reg  <= row_reg;
            peak_found_reg  <= peak_reg;
            rate_out_reg    <= rate_reg;
        end
    end

    assign in_stall       = (state_reg != efdhr_pkg::ST_IDLE);
    assign cfg_ready      = 1'b1;
    assign out_valid      = out_valid_reg;
    assign trace_value    = trace_value_reg;
    assign screen_row     = screen_row_reg;
    assign peak_found     = peak_found_reg;
    assign heart_rate_x16 = rate_out_reg;

endmodule

>>> rtl/core/efdhr_checker.sv
module efdhr_checker #(
    parameter int SCREEN_ROWS = 135
) (
    input logic               clk,
    input logic               rst_n,
    input logic               in_stall,
    input logic               out_valid,
    input logic               out_stall,
    input logic signed [23:0] trace_value,
    input logic [7:0]         screen_row
);

    // a stalled item stays offered
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("output item dropped under stall");

    // a stalled item holds its value
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(trace_value))
        else $error("output item changed under stall");

    // row stays on the display
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (32'(screen_row) <= SCREEN_ROWS - 1))
        else $error("screen row off the display");

    // a result only comes out while the sequencer is busy
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_stall))
        else $error("output item appeared while idle");

endmodule

bind ecg_filter_decimate_heart_rate_unit efdhr_checker #(.SCREEN_ROWS(SCREEN_ROWS)) u_chk (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_stall    (in_stall),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .trace_value (trace_value),
    .screen_row  (screen_row)
);
